/* rtl/lsc_pkg.sv */
// ----------------------------------------------------------------------------
// lsc_pkg: shared definitions for the lidar scan to Cartesian unit
// Widths, constants, register indexes, state codes and the arctangent table.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int MAX_SAMPLES  = 4096;
  localparam int CORDIC_STEPS = 16;

  localparam int RANGE_W       = 16;
  localparam int INTENSITY_W   = 16;
  localparam int ANGLE_W       = 32;
  localparam int XY_W          = 17;
  localparam int COUNT_OUT_W   = 13;
  localparam int COUNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int STEP_W        = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int ATAN_IDX_W    = 5;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 32;

  // Rotation datapath: 32-bit prescaled range grown by the CORDIC gain.
  localparam int DATA_W = 36;
  localparam int ZETA_W = 34;

  localparam logic [RANGE_W-1:0]     INV_GAIN_Q16      = 16'd39797;
  localparam logic [INTENSITY_W-1:0] DEFAULT_INTENSITY = 16'd100;
  localparam int                     MM_LIMIT          = 65535;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_RANGE     = 3'd0,
    REG_MAX_RANGE     = 3'd1,
    REG_START_ANGLE   = 3'd2,
    REG_ANGLE_STEP    = 3'd3,
    REG_HAS_INTENSITY = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROTATE,
    ST_DONE
  } cordic_state_t;

  // One classified sample, as handed from the front end to the rotation unit.
  typedef struct packed {
    logic [RANGE_W-1:0]     range_mm;
    logic [ANGLE_W-1:0]     angle;
    logic [INTENSITY_W-1:0] intensity;
    logic [COUNT_W-1:0]     count;
    logic                   point_valid;
    logic                   last_in_scan;
  } job_t;

  // atan(2^-i) in binary-angle units, 2^32 per turn.
  function automatic logic [ANGLE_W-1:0] atan_angle(input logic [ATAN_IDX_W-1:0] i);
    logic [ANGLE_W-1:0] a;
    case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/lsc_if.sv */
// ----------------------------------------------------------------------------
// lsc_if: channel interfaces of the lidar scan to Cartesian unit
// Sample input, point output and configuration write channels.
// ----------------------------------------------------------------------------
interface lsc_sample_if;
  logic                            valid;
  logic                            ready;
  logic [lsc_pkg::RANGE_W-1:0]     range_mm;
  logic                            not_finite;
  logic [lsc_pkg::INTENSITY_W-1:0] sample_intensity;
  logic                            last_in_scan;

  modport source (output valid, range_mm, not_finite, sample_intensity, last_in_scan,
                  input ready);
  modport sink   (input valid, range_mm, not_finite, sample_intensity, last_in_scan,
                  output ready);
endinterface

interface lsc_point_if;
  logic                            valid;
  logic                            ready;
  logic signed [lsc_pkg::XY_W-1:0] x_mm;
  logic signed [lsc_pkg::XY_W-1:0] y_mm;
  logic [lsc_pkg::INTENSITY_W-1:0] intensity_out;
  logic                            point_valid;
  logic                            scan_done;
  logic [lsc_pkg::COUNT_OUT_W-1:0] point_count;

  modport source (output valid, x_mm, y_mm, intensity_out, point_valid, scan_done,
                  point_count, input ready);
  modport sink   (input valid, x_mm, y_mm, intensity_out, point_valid, scan_done,
                  point_count, output ready);
endinterface

interface lsc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lsc_pkg::CFG_INDEX_W-1:0] index;
  logic [lsc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/lsc_front.sv */
// ----------------------------------------------------------------------------
// lsc_front: sample intake and classification
// Holds the configuration, applies the range filter, tracks the beam angle
// and the valid point count, and pushes one job per sample.
// ----------------------------------------------------------------------------
module lsc_front (
  input  logic              clk,
  input  logic              rst,
  lsc_sample_if.sink        samples,
  lsc_cfg_if.sink           cfg,
  input  logic              full,
  output logic              push,
  output lsc_pkg::job_t     push_job
);

  logic [lsc_pkg::RANGE_W-1:0] range_lo;
  logic [lsc_pkg::RANGE_W-1:0] range_hi;
  logic [lsc_pkg::ANGLE_W-1:0] start_angle;
  logic [lsc_pkg::ANGLE_W-1:0] angle_step;
  logic                        has_intensity;
  logic [lsc_pkg::ANGLE_W-1:0] beam_angle;
  logic [lsc_pkg::COUNT_W-1:0] points_in_scan;
  logic [lsc_pkg::COUNT_W-1:0] points_in_scan_next;
  logic                        in_range;

  assign cfg.ready     = 1'b1;
  assign samples.ready = !full;
  assign push          = samples.valid && !full;

  always_comb begin
    in_range = !samples.not_finite && (samples.range_mm >= range_lo)
               && (samples.range_mm <= range_hi);
    points_in_scan_next = points_in_scan;
    if (in_range && (points_in_scan < lsc_pkg::COUNT_W'(lsc_pkg::MAX_SAMPLES))) begin
      points_in_scan_next = points_in_scan + 1'b1;
    end
    push_job.range_mm     = samples.range_mm;
    push_job.angle        = beam_angle;
    push_job.count        = points_in_scan_next;
    push_job.point_valid  = in_range;
    push_job.last_in_scan = samples.last_in_scan;
    if (!in_range) begin
      push_job.intensity = '0;
    end else if (has_intensity) begin
      push_job.intensity = samples.sample_intensity;
    end else begin
      push_job.intensity = lsc_pkg::DEFAULT_INTENSITY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_lo       <= '0;
      range_hi       <= '1;
      start_angle    <= '0;
      angle_step     <= '0;
      has_intensity  <= 1'b0;
      beam_angle     <= '0;
      points_in_scan <= '0;
    end else begin
      if (push) begin
        if (samples.last_in_scan) begin
          beam_angle     <= start_angle;
          points_in_scan <= '0;
        end else begin
          beam_angle     <= beam_angle + angle_step;
          points_in_scan <= points_in_scan_next;
        end
      end
      if (cfg.valid) begin
        case (cfg.index)
          lsc_pkg::REG_MIN_RANGE:     range_lo      <= cfg.data[lsc_pkg::RANGE_W-1:0];
          lsc_pkg::REG_MAX_RANGE:     range_hi      <= cfg.data[lsc_pkg::RANGE_W-1:0];
          lsc_pkg::REG_START_ANGLE: begin
            start_angle <= cfg.data;
            beam_angle  <= cfg.data;
          end
          lsc_pkg::REG_ANGLE_STEP:    angle_step    <= cfg.data;
          lsc_pkg::REG_HAS_INTENSITY: has_intensity <= cfg.data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/lsc_queue.sv */
// ----------------------------------------------------------------------------
// lsc_queue: short job queue
// Register queue between the intake front end and the rotation unit.
// ----------------------------------------------------------------------------
module lsc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lsc_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output lsc_pkg::job_t head
);

  lsc_pkg::job_t                entries [lsc_pkg::QUEUE_DEPTH];
  logic [lsc_pkg::QPTR_W-1:0]   wr_ptr;
  logic [lsc_pkg::QPTR_W-1:0]   rd_ptr;
  logic [lsc_pkg::QCOUNT_W-1:0] fill;

  assign full      = (fill == lsc_pkg::QCOUNT_W'(lsc_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* rtl/lsc_cordic.sv */
// ----------------------------------------------------------------------------
// lsc_cordic: iterative rotation unit
// Prescales the range, folds the angle into the right half plane, runs the
// rotation steps and rounds the result into the output register.
// ----------------------------------------------------------------------------
module lsc_cordic (
  input  logic          clk,
  input  logic          rst,
  input  logic          not_empty,
  input  lsc_pkg::job_t head,
  output logic          pop,
  lsc_point_if.source   points
);

  localparam int DW = lsc_pkg::DATA_W;
  localparam int ZW = lsc_pkg::ZETA_W;
  localparam int RW = DW - 15;
  localparam logic signed [RW-1:0] LIMIT_POS = RW'(lsc_pkg::MM_LIMIT);
  localparam logic signed [RW-1:0] LIMIT_NEG = -RW'(lsc_pkg::MM_LIMIT);

  lsc_pkg::cordic_state_t state;
  lsc_pkg::cordic_state_t state_next;
  lsc_pkg::job_t          job;
  logic signed [DW-1:0]   x;
  logic signed [DW-1:0]   y;
  logic signed [ZW-1:0]   z;
  logic [lsc_pkg::STEP_W-1:0] step;
  logic                   out_valid;
  logic                   out_load;

  logic [2*lsc_pkg::RANGE_W-1:0] prod;
  logic                          fold;
  logic [lsc_pkg::ANGLE_W-1:0]   folded;
  logic signed [DW-1:0]          dx;
  logic signed [DW-1:0]          dy;
  logic signed [ZW-1:0]          atan_z;
  logic                          last_step;

  // Round half up to whole millimetres and clamp to the output range.
  function automatic logic signed [lsc_pkg::XY_W-1:0] to_mm(input logic signed [DW-1:0] v);
    logic signed [DW:0]   s;
    logic signed [RW-1:0] r;
    s = {v[DW-1], v} + (DW + 1)'(32768);
    r = s[DW:16];
    if (r > LIMIT_POS) begin
      r = LIMIT_POS;
    end else if (r < LIMIT_NEG) begin
      r = LIMIT_NEG;
    end
    return r[lsc_pkg::XY_W-1:0];
  endfunction

  always_comb begin
    prod      = lsc_pkg::RANGE_W'(job.range_mm) * lsc_pkg::INV_GAIN_Q16;
    fold      = job.angle[lsc_pkg::ANGLE_W-1] ^ job.angle[lsc_pkg::ANGLE_W-2];
    folded    = fold ? (job.angle + 32'h8000_0000) : job.angle;
    dx        = y >>> step;
    dy        = x >>> step;
    atan_z    = ZW'(lsc_pkg::atan_angle(lsc_pkg::ATAN_IDX_W'(step)));
    last_step = (step == lsc_pkg::STEP_W'(lsc_pkg::CORDIC_STEPS - 1));
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lsc_pkg::ST_IDLE: begin
        if (not_empty) state_next = lsc_pkg::ST_LOAD;
      end
      lsc_pkg::ST_LOAD: begin
        state_next = job.point_valid ? lsc_pkg::ST_ROTATE : lsc_pkg::ST_DONE;
      end
      lsc_pkg::ST_ROTATE: begin
        if (last_step) state_next = lsc_pkg::ST_DONE;
      end
      lsc_pkg::ST_DONE: begin
        if (!out_valid || points.ready) state_next = lsc_pkg::ST_IDLE;
      end
      default: state_next = lsc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    unique case (state)
      lsc_pkg::ST_IDLE:   pop      = not_empty;
      lsc_pkg::ST_LOAD:   ;
      lsc_pkg::ST_ROTATE: ;
      lsc_pkg::ST_DONE:   out_load = !out_valid || points.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    if (state == lsc_pkg::ST_LOAD) begin
      x    <= fold ? -$signed(DW'(prod)) : $signed(DW'(prod));
      y    <= '0;
      z    <= ZW'($signed(folded));
      step <= '0;
    end else if (state == lsc_pkg::ST_ROTATE) begin
      if (!z[ZW-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_z;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_z;
      end
      step <= step + 1'b1;
    end
  end

  // Output register: the next item can be fetched and rotated while this
  // one still waits for the sink.
  assign points.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (points.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      points.x_mm          <= job.point_valid ? to_mm(x) : '0;
      points.y_mm          <= job.point_valid ? to_mm(y) : '0;
      points.intensity_out <= job.intensity;
      points.point_valid   <= job.point_valid;
      points.scan_done     <= job.last_in_scan;
      points.point_count   <= lsc_pkg::COUNT_OUT_W'(job.count);
    end
  end

endmodule

/* rtl/lidar_scan_to_cartesian_unit.sv */
// ----------------------------------------------------------------------------
// lidar_scan_to_cartesian_unit: lidar range samples to Cartesian points
// Filters each range sample, tracks the beam angle and the valid point count
// of the scan, and projects accepted samples to x and y by CORDIC rotation.
// ----------------------------------------------------------------------------
//
//   Channel   Role      Handshake      Payload
//   samples   input     valid/ready    range_mm, not_finite, sample_intensity,
//                                      last_in_scan
//   points    output    valid/ready    x_mm, y_mm, intensity_out, point_valid,
//                                      scan_done, point_count
//   cfg       config    valid/ready    index (register number), data
//
// A point that passes the range filter goes through the rotation unit in
// order: fetch of the item from the queue, the range prescale multiply, 16
// CORDIC steps and rounding into the output register. A rejected sample
// skips the rotation steps. The single shared rotation unit sets the
// sustained rate. Reset (rst, synchronous) restores the register defaults
// and empties the queue. The two-entry queue lets the intake keep accepting
// while the rotation unit or the output is stalled, and the output register
// holds a finished point while the next is rotated.
//
// The front end accepts configuration writes without stalling; cfg.ready
// is always high.
//
module lidar_scan_to_cartesian_unit (
  input  logic        clk,
  input  logic        rst,
  lsc_sample_if.sink  samples,
  lsc_point_if.source points,
  lsc_cfg_if.sink     cfg
);

  logic          push;
  lsc_pkg::job_t push_job;
  logic          full;
  logic          pop;
  logic          not_empty;
  lsc_pkg::job_t head;

  // Intake: range filter, beam angle and point count bookkeeping.
  lsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .cfg      (cfg),
    .full     (full),
    .push     (push),
    .push_job (push_job)
  );

  // Decoupling queue between intake and rotation.
  lsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  // Rotation unit with the output register.
  lsc_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .points    (points)
  );

endmodule
